### hw/rtl/stepper_homing_setpoint_follower_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stepper homing setpoint follower
// Clocked, reset-qualified immediate-overlap and next-cycle property forms.
// ----------------------------------------------------------------------------
`ifndef STEPPER_HOMING_SETPOINT_FOLLOWER_UNIT_ASSERT_SVH
`define STEPPER_HOMING_SETPOINT_FOLLOWER_UNIT_ASSERT_SVH

// check cons in the same cycle as ante
`define SHF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define SHF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/shf_pkg.sv
// ----------------------------------------------------------------------------
// shf_pkg
// Types, register indexes and constants of the stepper homing follower.
// ----------------------------------------------------------------------------
`default_nettype none

package shf_pkg;

  localparam int unsigned SAMPLE_BITS   = 10;
  localparam int unsigned POSITION_BITS = 13;

  localparam int unsigned CHUNK_W  = 5;
  localparam int unsigned DBAND_W  = 8;
  localparam int unsigned LIMIT_W  = 10;
  localparam int unsigned GAIN_W   = 12;
  localparam int unsigned GAIN_FRAC = 10;
  localparam int unsigned STEPS_W  = 15;
  localparam int unsigned CODE_W   = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_CHUNK    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT_GAIN = 3'd3;

  localparam logic [CHUNK_W-1:0] RST_STEP_CHUNK    = 5'd5;
  localparam logic [DBAND_W-1:0] RST_DEADBAND      = 8'd10;
  localparam logic [LIMIT_W-1:0] RST_SEARCH_LIMIT  = 10'd310;
  localparam logic [GAIN_W-1:0]  RST_SETPOINT_GAIN = 12'd1249;

  typedef enum logic [CODE_W-1:0] {
    MODE_SEEK_START = 3'd0,
    MODE_SEEK_END   = 3'd1,
    MODE_RETURN     = 3'd2,
    MODE_TRACK      = 3'd3,
    MODE_RESEEK     = 3'd4,
    MODE_HALT       = 3'd5
  } mode_e;

  typedef struct packed {
    logic [CHUNK_W-1:0] step_chunk;
    logic [DBAND_W-1:0] deadband;
    logic [LIMIT_W-1:0] search_limit;
    logic [GAIN_W-1:0]  setpoint_gain;
  } cfg_t;

  typedef struct packed {
    logic vld;
    logic start_closed;
    logic end_closed;
  } stage_t;

endpackage

`default_nettype wire

### hw/rtl/shf_cfg_regs.sv
// ----------------------------------------------------------------------------
// shf_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module shf_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [shf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [shf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output      shf_pkg::cfg_t                   cfg_o
);
  import shf_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STEP_CHUNK:    cfg_d.step_chunk    = cfg_data_i[CHUNK_W-1:0];
        CFG_DEADBAND:      cfg_d.deadband      = cfg_data_i[DBAND_W-1:0];
        CFG_SEARCH_LIMIT:  cfg_d.search_limit  = cfg_data_i[LIMIT_W-1:0];
        CFG_SETPOINT_GAIN: cfg_d.setpoint_gain = cfg_data_i[GAIN_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_chunk    <= RST_STEP_CHUNK;
      cfg_q.deadband      <= RST_DEADBAND;
      cfg_q.search_limit  <= RST_SEARCH_LIMIT;
      cfg_q.setpoint_gain <= RST_SETPOINT_GAIN;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hw/rtl/shf_in_stage.sv
// ----------------------------------------------------------------------------
// shf_in_stage
// Input register: captures switch levels and the scaled, saturated target.
// ----------------------------------------------------------------------------
`default_nettype none

module shf_in_stage #(
  parameter int unsigned SampleBits   = shf_pkg::SAMPLE_BITS,
  parameter int unsigned PositionBits = shf_pkg::POSITION_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic                          start_switch_closed_i,
  input  wire logic                          end_switch_closed_i,
  input  wire logic [SampleBits-1:0]         setpoint_sample_i,
  input  wire logic [shf_pkg::GAIN_W-1:0]    gain_i,
  input  wire logic                          out_ready_i,
  output      shf_pkg::stage_t               stage_o,
  output      logic [PositionBits-1:0]       target_o
);
  import shf_pkg::*;

  localparam int unsigned ProdW   = SampleBits + GAIN_W;
  localparam int unsigned ScaledW = ProdW - GAIN_FRAC;
  localparam int unsigned CmpW    = (ScaledW > PositionBits) ? ScaledW : PositionBits;
  localparam logic [CmpW-1:0] PosMaxExt = CmpW'({PositionBits{1'b1}});

  logic                    vld_q, vld_d;
  logic                    start_q, end_q;
  logic [PositionBits-1:0] target_q, target_d;
  logic [ProdW-1:0]        prod;
  logic [CmpW-1:0]         scaled_ext;
  logic                    accept, adv;

  assign adv        = vld_q & out_ready_i;
  assign in_stall_o = vld_q & ~out_ready_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign vld_d      = accept | (vld_q & ~adv);

  assign prod       = ProdW'(setpoint_sample_i) * ProdW'(gain_i);
  assign scaled_ext = CmpW'(prod[ProdW-1:GAIN_FRAC]);

  always_comb begin
    if (scaled_ext > PosMaxExt) begin
      target_d = {PositionBits{1'b1}};
    end else begin
      target_d = scaled_ext[PositionBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      start_q  <= start_switch_closed_i;
      end_q    <= end_switch_closed_i;
      target_q <= target_d;
    end
  end

  assign stage_o.vld          = vld_q;
  assign stage_o.start_closed = start_q;
  assign stage_o.end_closed   = end_q;
  assign target_o             = target_q;

endmodule

`default_nettype wire

### hw/rtl/shf_ctrl.sv
// ----------------------------------------------------------------------------
// shf_ctrl
// Homing and tracking state machine with the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module shf_ctrl #(
  parameter int unsigned PositionBits = shf_pkg::POSITION_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire shf_pkg::cfg_t                 cfg_i,
  input  wire shf_pkg::stage_t               stage_i,
  input  wire logic [PositionBits-1:0]       target_i,
  output      logic                          out_ready_o,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic [shf_pkg::STEPS_W-1:0]   move_steps_o,
  output      logic                          move_forward_o,
  output      logic                          lamp_on_o,
  output      logic [shf_pkg::CODE_W-1:0]    mode_code_o
);
  import shf_pkg::*;

  mode_e                   mode_q, mode_d;
  logic [LIMIT_W-1:0]      cnt_q, cnt_d;
  logic [STEPS_W-1:0]      travel_q, travel_d;
  logic [PositionBits-1:0] pos_q, pos_d;

  logic                    out_vld_q, out_vld_d;
  logic [STEPS_W-1:0]      steps_q, steps;
  logic                    fwd_q, fwd;
  logic                    lamp_q, lamp;
  logic [CODE_W-1:0]       code_q, code;

  logic                    adv;
  logic [STEPS_W-1:0]      chunk_ext, travel_prod;
  logic [PositionBits-1:0] chunk_pos, dband_pos, diff_up, diff_dn;
  logic [PositionBits:0]   pos_sum;
  logic                    up_ok, dn_ok, s_cl, e_cl;

  assign out_ready_o = ~out_vld_q | ~out_stall_i;
  assign adv         = stage_i.vld & out_ready_o;
  assign s_cl        = stage_i.start_closed;
  assign e_cl        = stage_i.end_closed;

  assign chunk_ext   = STEPS_W'(cfg_i.step_chunk);
  assign travel_prod = STEPS_W'(cnt_q) * chunk_ext;
  assign chunk_pos   = PositionBits'(cfg_i.step_chunk);
  assign dband_pos   = PositionBits'(cfg_i.deadband);
  assign diff_up     = target_i - pos_q;
  assign diff_dn     = pos_q - target_i;
  assign pos_sum     = {1'b0, pos_q} + {1'b0, chunk_pos};
  assign up_ok       = (target_i > pos_q) && (diff_up > dband_pos) && !e_cl;
  assign dn_ok       = (pos_q > target_i) && (diff_dn > dband_pos) && !s_cl;

  always_comb begin
    mode_d   = mode_q;
    cnt_d    = cnt_q;
    travel_d = travel_q;
    pos_d    = pos_q;
    steps    = '0;
    fwd      = 1'b0;
    lamp     = 1'b1;
    code     = mode_q;
    case (mode_q)
      MODE_SEEK_START, MODE_RESEEK: begin
        if (s_cl) begin
          lamp   = 1'b0;
          mode_d = (mode_q == MODE_SEEK_START) ? MODE_SEEK_END : MODE_HALT;
          cnt_d  = '0;
        end else if (cnt_q >= cfg_i.search_limit) begin
          mode_d = MODE_HALT;
        end else begin
          cnt_d = cnt_q + LIMIT_W'(1);
          steps = chunk_ext;
        end
      end
      MODE_SEEK_END: begin
        if (e_cl) begin
          lamp     = 1'b0;
          travel_d = travel_prod;
          mode_d   = MODE_RETURN;
        end else if (cnt_q >= cfg_i.search_limit) begin
          cnt_d  = '0;
          mode_d = MODE_RESEEK;
        end else begin
          cnt_d = cnt_q + LIMIT_W'(1);
          steps = chunk_ext;
          fwd   = 1'b1;
        end
      end
      MODE_RETURN: begin
        steps  = travel_q;
        lamp   = 1'b0;
        pos_d  = '0;
        mode_d = MODE_TRACK;
      end
      MODE_TRACK: begin
        lamp = ~(s_cl | e_cl);
        if (up_ok) begin
          steps = chunk_ext;
          fwd   = 1'b1;
          pos_d = pos_sum[PositionBits] ? {PositionBits{1'b1}} : pos_sum[PositionBits-1:0];
        end else if (dn_ok) begin
          steps = chunk_ext;
          pos_d = (pos_q >= chunk_pos) ? (pos_q - chunk_pos) : '0;
        end
      end
      default: begin
        code = MODE_HALT;
      end
    endcase
  end

  assign out_vld_d = adv | (out_vld_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_SEEK_START;
      cnt_q     <= '0;
      travel_q  <= '0;
      pos_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (adv) begin
        mode_q   <= mode_d;
        cnt_q    <= cnt_d;
        travel_q <= travel_d;
        pos_q    <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      steps_q <= steps;
      fwd_q   <= fwd & (steps != '0);
      lamp_q  <= lamp;
      code_q  <= code;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign move_steps_o   = steps_q;
  assign move_forward_o = fwd_q;
  assign lamp_on_o      = lamp_q;
  assign mode_code_o    = code_q;

endmodule

`default_nettype wire

### hw/rtl/stepper_homing_setpoint_follower_unit.sv
// ----------------------------------------------------------------------------
// stepper_homing_setpoint_follower_unit
// Homes a stepper axis between two end-stop switches, then follows a scaled
// setpoint in fixed chunks with a deadband.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------
//   in      | input     | in_valid_i / in_stall_o | start/end switch, setpoint
//   out     | output    | out_valid_o / out_stall_i | steps, forward, lamp, mode
//   cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One item per cycle while the output is not stalled.
// The setpoint multiply sits before the input register, the mode update
// between the input register and the result register.
// Reset puts the block in start-switch search with all counts at zero.
// A stalled result holds the input register; a further item is then refused.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_homing_setpoint_follower_unit #(
  parameter int unsigned SampleBits   = shf_pkg::SAMPLE_BITS,
  parameter int unsigned PositionBits = shf_pkg::POSITION_BITS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [shf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [shf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                            in_valid_i,
  output      logic                            in_stall_o,
  input  wire logic                            start_switch_closed_i,
  input  wire logic                            end_switch_closed_i,
  input  wire logic [SampleBits-1:0]           setpoint_sample_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output      logic [shf_pkg::STEPS_W-1:0]     move_steps_o,
  output      logic                            move_forward_o,
  output      logic                            lamp_on_o,
  output      logic [shf_pkg::CODE_W-1:0]      mode_code_o
);
  import shf_pkg::*;

  cfg_t                    cfg;
  stage_t                  stage;
  logic [PositionBits-1:0] target;
  logic                    out_ready;

  shf_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  shf_in_stage #(
    .SampleBits   (SampleBits),
    .PositionBits (PositionBits)
  ) u_in (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .start_switch_closed_i (start_switch_closed_i),
    .end_switch_closed_i   (end_switch_closed_i),
    .setpoint_sample_i     (setpoint_sample_i),
    .gain_i                (cfg.setpoint_gain),
    .out_ready_i           (out_ready),
    .stage_o               (stage),
    .target_o              (target)
  );

  shf_ctrl #(
    .PositionBits (PositionBits)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .stage_i        (stage),
    .target_i       (target),
    .out_ready_o    (out_ready),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .move_steps_o   (move_steps_o),
    .move_forward_o (move_forward_o),
    .lamp_on_o      (lamp_on_o),
    .mode_code_o    (mode_code_o)
  );

endmodule

`default_nettype wire

### hw/rtl/shf_checker.sv
// ----------------------------------------------------------------------------
// shf_checker
// Port-level checks of the stepper homing follower, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stepper_homing_setpoint_follower_unit_assert.svh"

module shf_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_stall_o,
  input wire logic                            out_valid_o,
  input wire logic                            out_stall_i,
  input wire logic [shf_pkg::STEPS_W-1:0]     move_steps_o,
  input wire logic                            move_forward_o,
  input wire logic                            lamp_on_o,
  input wire logic [shf_pkg::CODE_W-1:0]      mode_code_o
);
  import shf_pkg::*;

  `SHF_ASSERT_SAME(a_fwd_needs_steps, clk_i, rst_ni, out_valid_o && move_forward_o,
    move_steps_o != '0, "forward flag on a zero move")

  `SHF_ASSERT_SAME(a_return_dark, clk_i, rst_ni, out_valid_o && (mode_code_o == MODE_RETURN),
    !move_forward_o && !lamp_on_o, "return item must move backward with lamp off")

  `SHF_ASSERT_SAME(a_halt_idle, clk_i, rst_ni, out_valid_o && (mode_code_o == MODE_HALT),
    (move_steps_o == '0) && lamp_on_o, "halted item must not move")

  `SHF_ASSERT_SAME(a_stall_only_backed_up, clk_i, rst_ni, in_stall_o,
    out_valid_o && out_stall_i, "input stalled while output free")

  `SHF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(move_steps_o) && $stable(mode_code_o), "stalled result changed")

endmodule

bind stepper_homing_setpoint_follower_unit shf_checker u_shf_checker (.*);

`default_nettype wire

### tb/shf_command_checker.sv
// ----------------------------------------------------------------------------
// Move command checker for the stepper homing setpoint follower
// Follows the configuration port and both channels, predicts the move command
// of every accepted tick from its own copy of the homing and tracking state,
// and compares each accepted command field by field with the oldest one due.
// ----------------------------------------------------------------------------
module shf_command_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [shf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [shf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic                            start_closed_i,
  input  logic                            end_closed_i,
  input  logic [shf_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [shf_pkg::STEPS_W-1:0]     move_steps_i,
  input  logic                            move_forward_i,
  input  logic                            lamp_on_i,
  input  logic [shf_pkg::CODE_W-1:0]      mode_code_i,
  output int                              mismatches_o,
  output int                              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import shf_pkg::*;

  typedef struct packed {
    logic [STEPS_W-1:0] steps;
    logic               forward;
    logic               lamp;
    logic [CODE_W-1:0]  code;
  } command_t;

  logic [CHUNK_W-1:0]       step_chunk;
  logic [DBAND_W-1:0]       deadband;
  logic [LIMIT_W-1:0]       search_limit;
  logic [GAIN_W-1:0]        setpoint_gain;

  mode_e                    mode;
  logic [LIMIT_W-1:0]       search_count;
  logic [STEPS_W-1:0]       travel_steps;
  logic [POSITION_BITS-1:0] position;

  command_t                 command_q[$];
  int                       errors;

  function automatic command_t next_command(input logic s_closed, input logic e_closed,
                                            input logic [SAMPLE_BITS-1:0] smp);
    command_t    cmd;
    int unsigned target;
    int unsigned pos;
    int unsigned pos_top;
    cmd      = '0;
    cmd.code = mode;
    pos_top  = (1 << POSITION_BITS) - 1;
    case (mode)
      MODE_SEEK_START, MODE_RESEEK: begin
        if (s_closed) begin
          mode         = (mode == MODE_SEEK_START) ? MODE_SEEK_END : MODE_HALT;
          search_count = '0;
        end else if (search_count >= search_limit) begin
          cmd.lamp = 1'b1;
          mode     = MODE_HALT;
        end else begin
          search_count = search_count + 1'b1;
          cmd.steps    = STEPS_W'(step_chunk);
          cmd.lamp     = 1'b1;
        end
      end
      MODE_SEEK_END: begin
        if (e_closed) begin
          travel_steps = STEPS_W'(search_count) * STEPS_W'(step_chunk);
          mode         = MODE_RETURN;
        end else if (search_count >= search_limit) begin
          cmd.lamp     = 1'b1;
          search_count = '0;
          mode         = MODE_RESEEK;
        end else begin
          search_count = search_count + 1'b1;
          cmd.steps    = STEPS_W'(step_chunk);
          cmd.forward  = 1'b1;
          cmd.lamp     = 1'b1;
        end
      end
      MODE_RETURN: begin
        cmd.steps = travel_steps;
        position  = '0;
        mode      = MODE_TRACK;
      end
      MODE_TRACK: begin
        target = (32'(smp) * 32'(setpoint_gain)) >> GAIN_FRAC;
        if (target > pos_top) target = pos_top;
        pos      = position;
        cmd.lamp = !(s_closed || e_closed);
        if (target > pos && (target - pos) > deadband && !e_closed) begin
          cmd.steps   = STEPS_W'(step_chunk);
          cmd.forward = 1'b1;
          pos         = (pos + step_chunk > pos_top) ? pos_top : pos + step_chunk;
        end else if (pos > target && (pos - target) > deadband && !s_closed) begin
          cmd.steps = STEPS_W'(step_chunk);
          pos       = (pos >= step_chunk) ? pos - step_chunk : 0;
        end
        position = POSITION_BITS'(pos);
      end
      default: begin
        cmd.code = MODE_HALT;
        cmd.lamp = 1'b1;
      end
    endcase
    if (cmd.steps == '0) cmd.forward = 1'b0;
    return cmd;
  endfunction

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    command_t want;
    if (!rst_ni) begin
      step_chunk    = RST_STEP_CHUNK;
      deadband      = RST_DEADBAND;
      search_limit  = RST_SEARCH_LIMIT;
      setpoint_gain = RST_SETPOINT_GAIN;
      mode          = MODE_SEEK_START;
      search_count  = '0;
      travel_steps  = '0;
      position      = '0;
      command_q.delete();
      errors        = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_STEP_CHUNK:    step_chunk    = cfg_data_i[CHUNK_W-1:0];
          CFG_DEADBAND:      deadband      = cfg_data_i[DBAND_W-1:0];
          CFG_SEARCH_LIMIT:  search_limit  = cfg_data_i[LIMIT_W-1:0];
          CFG_SETPOINT_GAIN: setpoint_gain = cfg_data_i[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (command_q.size() == 0) begin
          errors++;
          $display("%0t ns: command with none expected, got steps %0d fwd %0b lamp %0b mode %0d",
                   $time, move_steps_i, move_forward_i, lamp_on_i, mode_code_i);
        end else begin
          want = command_q.pop_front();
          check_field("move_steps", want.steps, move_steps_i);
          check_field("move_forward", want.forward, move_forward_i);
          check_field("lamp_on", want.lamp, lamp_on_i);
          check_field("mode_code", want.code, mode_code_i);
        end
      end
      if (in_valid_i && !in_stall_i)
        command_q.push_back(next_command(start_closed_i, end_closed_i, sample_i));
      mismatches_o <= errors;
      pending_o    <= command_q.size();
    end
  end

endmodule

### tb/stepper_homing_setpoint_follower_unit_tb.sv
// ----------------------------------------------------------------------------
// Testbench for stepper_homing_setpoint_follower_unit
// Homes the axis through start search, end search and return, then drives
// setpoint tracking across many register settings with random gaps on both
// channels and at least one long output hold-off. Some runs take a search fault path
// instead and finish in the halted mode. A checker module predicts and
// compares every move command.
// ----------------------------------------------------------------------------
module stepper_homing_setpoint_follower_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import shf_pkg::*;

  localparam int HOLD_CYCLES  = 200;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 800;
  localparam int LONG_SEARCH  = 1023;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic                   start_switch_closed_i;
  logic                   end_switch_closed_i;
  logic [SAMPLE_BITS-1:0] setpoint_sample_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [STEPS_W-1:0]     move_steps_o;
  logic                   move_forward_o;
  logic                   lamp_on_o;
  logic [CODE_W-1:0]      mode_code_o;

  int                     mismatches;
  int                     pending;
  int                     idle_cycles = 0;
  bit                     quiet = 1'b0;
  bit                     hold_req = 1'b0;
  logic [SAMPLE_BITS-1:0] walk_sample = '0;

  stepper_homing_setpoint_follower_unit u_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .start_switch_closed_i (start_switch_closed_i),
    .end_switch_closed_i   (end_switch_closed_i),
    .setpoint_sample_i     (setpoint_sample_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .move_steps_o          (move_steps_o),
    .move_forward_o        (move_forward_o),
    .lamp_on_o             (lamp_on_o),
    .mode_code_o           (mode_code_o)
  );

  shf_command_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .start_closed_i (start_switch_closed_i),
    .end_closed_i   (end_switch_closed_i),
    .sample_i       (setpoint_sample_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .move_steps_i   (move_steps_o),
    .move_forward_i (move_forward_o),
    .lamp_on_i      (lamp_on_o),
    .mode_code_i    (mode_code_o),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] cfg_value(input logic [CFG_IDX_W-1:0] idx);
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    case (idx)
      CFG_STEP_CHUNK:   begin lo = 12'd1; hi = 12'd31;   end
      CFG_DEADBAND:     begin lo = 12'd0; hi = 12'd255;  end
      CFG_SEARCH_LIMIT: begin lo = 12'd1; hi = 12'd1023; end
      default:          begin lo = 12'd0; hi = 12'd4095; end
    endcase
    case ($urandom_range(0, 3))
      0:       return lo;
      1:       return hi;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  initial begin : receiver
    int n;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i = 1'b0;
        hold_req    = 1'b0;
      end else if (quiet) begin
        out_stall_i = 1'b0;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall_i = 1'b1;
          repeat (n) @(negedge clk_i);
        end
        out_stall_i = 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk_i);
      end
    end
  end

  task automatic tick(input logic s, input logic e, input logic [SAMPLE_BITS-1:0] smp);
    int gap;
    gap = quiet ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i            = 1'b1;
    start_switch_closed_i = s;
    end_switch_closed_i   = e;
    setpoint_sample_i     = smp;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // keep the sought switch open, the other one random
  task automatic search_ticks(input bit seek_start, input int n);
    repeat (n) begin
      if (seek_start) tick(1'b0, 1'($urandom), SAMPLE_BITS'($urandom));
      else tick(1'($urandom), 1'b0, SAMPLE_BITS'($urandom));
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  task automatic shuffle_config();
    logic [CFG_IDX_W-1:0] idx;
    for (int i = 0; i <= int'(CFG_SETPOINT_GAIN); i++) begin
      idx = CFG_IDX_W'(i);
      if ($urandom_range(0, 1) == 1) write_reg(idx, cfg_value(idx));
    end
    if ($urandom_range(0, 7) == 0)
      write_reg(CFG_SETPOINT_GAIN + CFG_IDX_W'($urandom_range(1, 4)), CFG_DATA_W'($urandom));
  endtask

  initial begin : stimulus
    int  lim;
    int  n;
    int  len;
    int  sent;
    bit  first;
    bit  fault_run;
    bit  long_run;
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = CFG_STEP_CHUNK;
    cfg_data_i            = '0;
    in_valid_i            = 1'b0;
    start_switch_closed_i = 1'b0;
    end_switch_closed_i   = 1'b0;
    setpoint_sample_i     = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    fault_run = ($urandom_range(0, 5) == 0);
    long_run  = !fault_run && ($urandom_range(0, 7) == 0);

    if (fault_run) begin
      lim = $urandom_range(0, 2);
      drain();
      write_reg(CFG_SEARCH_LIMIT, CFG_DATA_W'(lim));
      case ($urandom_range(0, 2))
        0: search_ticks(1'b1, lim + 1);
        1: begin
          tick(1'b1, 1'($urandom), SAMPLE_BITS'($urandom));
          search_ticks(1'b0, lim + 1);
          search_ticks(1'b1, $urandom_range(0, lim));
          tick(1'b1, 1'($urandom), SAMPLE_BITS'($urandom));
        end
        default: begin
          tick(1'b1, 1'($urandom), SAMPLE_BITS'($urandom));
          search_ticks(1'b0, lim + 1);
          search_ticks(1'b1, lim + 1);
        end
      endcase
    end else begin
      // start search under reset settings, then close the switch right at the limit
      search_ticks(1'b1, 2);
      drain();
      lim = $urandom_range(2, 4);
      write_reg(CFG_SEARCH_LIMIT, CFG_DATA_W'(lim));
      search_ticks(1'b1, lim - 2);
      tick(1'b1, 1'($urandom), SAMPLE_BITS'($urandom));
      drain();
      if (long_run) begin
        n = LONG_SEARCH;
        write_reg(CFG_STEP_CHUNK, 12'd31);
      end else begin
        n = $urandom_range(0, 3);
        write_reg(CFG_STEP_CHUNK, cfg_value(CFG_STEP_CHUNK));
      end
      write_reg(CFG_SEARCH_LIMIT, CFG_DATA_W'(n));
      search_ticks(1'b0, n);
      tick(1'($urandom), 1'b1, SAMPLE_BITS'($urandom));
      tick(1'($urandom), 1'($urandom), SAMPLE_BITS'($urandom));

      drain();
      write_reg(CFG_STEP_CHUNK, 12'd7);
      write_reg(CFG_DEADBAND, 12'd0);
      write_reg(CFG_SETPOINT_GAIN, 12'd1024);
      tick(1'b0, 1'b0, 10'd5);
      drain();
      // a chunk larger than the position clamps it at zero
      write_reg(CFG_STEP_CHUNK, 12'd31);
      tick(1'b0, 1'b0, 10'd0);
      drain();
      write_reg(CFG_SETPOINT_GAIN, 12'd4095);
      tick(1'b0, 1'b0, 10'd1023);
      tick(1'b0, 1'b1, 10'd1023);
      tick(1'b1, 1'b0, 10'd0);
      tick(1'b0, 1'b0, 10'd0);
      drain();
      // oversized data truncates; chunk becomes zero
      write_reg(CFG_STEP_CHUNK, 12'd32);
      write_reg(CFG_DEADBAND, 12'hFFF);
      write_reg(CFG_SETPOINT_GAIN + CFG_IDX_W'(1), 12'h0A5);
      tick(1'b0, 1'b0, 10'd1023);
      tick(1'b1, 1'b1, 10'd512);
      drain();
      write_reg(CFG_STEP_CHUNK, CFG_DATA_W'(RST_STEP_CHUNK));
      write_reg(CFG_DEADBAND, CFG_DATA_W'(RST_DEADBAND));
      write_reg(CFG_SETPOINT_GAIN, CFG_DATA_W'(RST_SETPOINT_GAIN));
    end

    sent  = 0;
    first = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      drain();
      shuffle_config();
      quiet = ($urandom_range(0, 3) == 0);
      if (first || $urandom_range(0, 7) == 0) begin
        quiet    = 1'b0;
        hold_req = 1'b1;
      end
      first = 1'b0;
      len   = $urandom_range(20, 120);
      repeat (len) begin
        case ($urandom_range(0, 9))
          0:       walk_sample = '0;
          1:       walk_sample = '1;
          2:       walk_sample = SAMPLE_BITS'($urandom);
          default: walk_sample = walk_sample + SAMPLE_BITS'($urandom_range(0, 6)) - 3'd3;
        endcase
        tick($urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0, walk_sample);
      end
      sent += len;
    end

    quiet = 1'b0;
    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
